### hw/rtl/ter_pkg.sv
// shared widths, codes and beat types for the triangle edge rasterizer
`timescale 1ns / 1ps
`default_nettype none

package ter_pkg;

  // vertex coordinate width (two's complement)
  localparam int COORD_BITS  = 12;
  // pixel coordinate and screen register widths
  localparam int PIX_W       = 11;
  localparam int SCREEN_W    = 12;
  localparam int SCREEN_MAX  = 2048;
  localparam int COLOR_W     = 4;
  localparam int LAYER_W     = 4;
  localparam int COLOR_SHIFT = 4;
  localparam int ATTR_W      = COLOR_W + COLOR_SHIFT;

  // offsets and coefficients must hold a vertex difference and a pixel minus vertex
  localparam int OFS_W  = ((COORD_BITS > PIX_W + 1) ? COORD_BITS : PIX_W + 1) + 1;
  localparam int PROD_W = 2 * OFS_W;
  localparam int EDGE_W = PROD_W + 1;

  // commands
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  // configuration register indexes
  localparam int   CFG_IDX_W         = 1;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 1'b1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [OFS_W-1:0]      ofs_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [EDGE_W-1:0]     edge_t;
  typedef logic [PIX_W-1:0]             pix_t;
  typedef logic [SCREEN_W-1:0]          screen_t;
  typedef logic [COLOR_W-1:0]           color_t;
  typedef logic [LAYER_W-1:0]           layer_t;

  // input beat after the input register, with vertex differences and extents
  typedef struct packed {
    logic   cmd;
    coord_t ax;
    coord_t ay;
    coord_t bx;
    coord_t by;
    coord_t cx;
    coord_t cy;
    ofs_t   dx_ab;
    ofs_t   dy_ab;
    ofs_t   dx_bc;
    ofs_t   dy_bc;
    ofs_t   dx_ca;
    ofs_t   dy_ca;
    ofs_t   dx_ac;
    ofs_t   dy_ac;
    coord_t min_x;
    coord_t max_x;
    coord_t min_y;
    coord_t max_y;
    color_t color;
    layer_t layer;
  } item_t;

  // result beat on its way to edge evaluation: e_i = dx_i * oy_i - dy_i * ox_i
  typedef struct packed {
    pix_t   px;
    pix_t   py;
    color_t color;
    layer_t layer;
    logic   empty;
    logic   last;
    ofs_t   dx0;
    ofs_t   dy0;
    ofs_t   ox0;
    ofs_t   oy0;
    ofs_t   dx1;
    ofs_t   dy1;
    ofs_t   ox1;
    ofs_t   oy1;
    ofs_t   dx2;
    ofs_t   dy2;
    ofs_t   ox2;
    ofs_t   oy2;
  } pix_beat_t;

  // result beat after the multipliers
  typedef struct packed {
    pix_t   px;
    pix_t   py;
    color_t color;
    layer_t layer;
    logic   empty;
    logic   last;
    prod_t  p0a;
    prod_t  p0b;
    prod_t  p1a;
    prod_t  p1b;
    prod_t  p2a;
    prod_t  p2b;
  } prod_beat_t;

endpackage

`default_nettype wire

### hw/rtl/triangle_edge_rasterizer.sv
// top level of the edge function triangle rasterizer
// a beat passes the input, scan, product and output registers before it leaves
// throughput: one beat per cycle while out_stall is low; set by those registers
// a load with a nonempty triangle and a step while idle give no result beat
// reset: synchronous; scan goes idle, screen size returns to 120 by 40
`timescale 1ns / 1ps
`default_nettype none

module triangle_edge_rasterizer (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_write,
  input  wire logic [ter_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire ter_pkg::screen_t                  cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              cmd,
  input  wire ter_pkg::coord_t                   ax,
  input  wire ter_pkg::coord_t                   ay,
  input  wire ter_pkg::coord_t                   bx,
  input  wire ter_pkg::coord_t                   by_row,
  input  wire ter_pkg::coord_t                   cx,
  input  wire ter_pkg::coord_t                   cy,
  input  wire ter_pkg::color_t                   fill_color,
  input  wire ter_pkg::layer_t                   layer,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output ter_pkg::pix_t                          pixel_x,
  output ter_pkg::pix_t                          pixel_y,
  output logic                                   covered,
  output logic [ter_pkg::ATTR_W-1:0]             attribute,
  output ter_pkg::layer_t                        layer_out,
  output logic                                   empty_res,
  output logic                                   last
);

  logic               take_ready;
  logic               item_valid;
  ter_pkg::item_t     item;
  logic               eval_ready;
  logic               pix_valid;
  ter_pkg::pix_beat_t pix;

  // input register
  ter_input_stage u_input (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .cmd        (cmd),
    .ax         (ax),
    .ay         (ay),
    .bx         (bx),
    .by_row     (by_row),
    .cx         (cx),
    .cy         (cy),
    .fill_color (fill_color),
    .layer      (layer),
    .take_ready (take_ready),
    .item_valid (item_valid),
    .item       (item)
  );

  // setup and scan
  ter_scan_ctrl u_scan (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .item       (item),
    .take_ready (take_ready),
    .eval_ready (eval_ready),
    .pix_valid  (pix_valid),
    .pix        (pix)
  );

  // edge evaluation and output register
  ter_edge_eval u_edge (
    .clk        (clk),
    .rst        (rst),
    .pix_valid  (pix_valid),
    .pix        (pix),
    .eval_ready (eval_ready),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .covered    (covered),
    .attribute  (attribute),
    .layer_out  (layer_out),
    .empty_res  (empty_res),
    .last       (last)
  );

endmodule

`default_nettype wire

### hw/rtl/ter_input_stage.sv
// input register with vertex differences and bounding extents
`timescale 1ns / 1ps
`default_nettype none

module ter_input_stage (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  cmd,
  input  wire ter_pkg::coord_t       ax,
  input  wire ter_pkg::coord_t       ay,
  input  wire ter_pkg::coord_t       bx,
  input  wire ter_pkg::coord_t       by_row,
  input  wire ter_pkg::coord_t       cx,
  input  wire ter_pkg::coord_t       cy,
  input  wire ter_pkg::color_t       fill_color,
  input  wire ter_pkg::layer_t       layer,
  input  wire logic                  take_ready,
  output logic                       item_valid,
  output ter_pkg::item_t             item
);

  logic           ready_in;
  ter_pkg::item_t item_next;
  ter_pkg::coord_t min_x;
  ter_pkg::coord_t max_x;
  ter_pkg::coord_t min_y;
  ter_pkg::coord_t max_y;

  assign ready_in = !item_valid || take_ready;
  assign in_stall = !ready_in;

  // extents of the three vertices
  always_comb begin
    min_x = (ax < bx) ? ax : bx;
    min_x = (min_x < cx) ? min_x : cx;
    max_x = (ax > bx) ? ax : bx;
    max_x = (max_x > cx) ? max_x : cx;
    min_y = (ay < by_row) ? ay : by_row;
    min_y = (min_y < cy) ? min_y : cy;
    max_y = (ay > by_row) ? ay : by_row;
    max_y = (max_y > cy) ? max_y : cy;
  end

  // edge coefficients and area operands
  always_comb begin
    item_next       = '0;
    item_next.cmd   = cmd;
    item_next.ax    = ax;
    item_next.ay    = ay;
    item_next.bx    = bx;
    item_next.by    = by_row;
    item_next.cx    = cx;
    item_next.cy    = cy;
    item_next.dx_ab = ter_pkg::ofs_t'(bx) - ter_pkg::ofs_t'(ax);
    item_next.dy_ab = ter_pkg::ofs_t'(by_row) - ter_pkg::ofs_t'(ay);
    item_next.dx_bc = ter_pkg::ofs_t'(cx) - ter_pkg::ofs_t'(bx);
    item_next.dy_bc = ter_pkg::ofs_t'(cy) - ter_pkg::ofs_t'(by_row);
    item_next.dx_ca = ter_pkg::ofs_t'(ax) - ter_pkg::ofs_t'(cx);
    item_next.dy_ca = ter_pkg::ofs_t'(ay) - ter_pkg::ofs_t'(cy);
    item_next.dx_ac = ter_pkg::ofs_t'(cx) - ter_pkg::ofs_t'(ax);
    item_next.dy_ac = ter_pkg::ofs_t'(cy) - ter_pkg::ofs_t'(ay);
    item_next.min_x = min_x;
    item_next.max_x = max_x;
    item_next.min_y = min_y;
    item_next.max_y = max_y;
    item_next.color = fill_color;
    item_next.layer = layer;
  end

  // beat valid
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (ready_in) begin
      item_valid <= in_valid;
    end
  end

  // beat payload
  always_ff @(posedge clk) begin
    if (ready_in && in_valid) begin
      item <= item_next;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/ter_scan_ctrl.sv
// triangle setup, clipping and raster scan state
`timescale 1ns / 1ps
`default_nettype none

module ter_scan_ctrl (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_write,
  input  wire logic [ter_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire ter_pkg::screen_t                  cfg_data,
  input  wire logic                              item_valid,
  input  wire ter_pkg::item_t                    item,
  output logic                                   take_ready,
  input  wire logic                              eval_ready,
  output logic                                   pix_valid,
  output ter_pkg::pix_beat_t                     pix
);

  // configuration
  ter_pkg::screen_t screen_width;
  ter_pkg::screen_t screen_height;

  // triangle and scan state
  logic             active;
  ter_pkg::coord_t  vx_a;
  ter_pkg::coord_t  vy_a;
  ter_pkg::coord_t  vx_b;
  ter_pkg::coord_t  vy_b;
  ter_pkg::coord_t  vx_c;
  ter_pkg::coord_t  vy_c;
  ter_pkg::ofs_t    k_dx0;
  ter_pkg::ofs_t    k_dy0;
  ter_pkg::ofs_t    k_dx1;
  ter_pkg::ofs_t    k_dy1;
  ter_pkg::ofs_t    k_dx2;
  ter_pkg::ofs_t    k_dy2;
  ter_pkg::pix_t    box_lo_x;
  ter_pkg::pix_t    box_hi_x;
  ter_pkg::pix_t    box_lo_y;
  ter_pkg::pix_t    box_hi_y;
  ter_pkg::pix_t    scan_x;
  ter_pkg::pix_t    scan_y;
  ter_pkg::color_t  held_color;
  ter_pkg::layer_t  held_layer;

  ter_pkg::screen_t   w_sat;
  ter_pkg::screen_t   h_sat;
  ter_pkg::ofs_t      w_lim;
  ter_pkg::ofs_t      h_lim;
  ter_pkg::ofs_t      lo_x;
  ter_pkg::ofs_t      hi_x;
  ter_pkg::ofs_t      lo_y;
  ter_pkg::ofs_t      hi_y;
  logic               area_zero;
  logic               tri_empty;
  logic               is_load;
  logic               fire;
  logic               emit;
  logic               end_row;
  logic               fin;
  ter_pkg::ofs_t      px_s;
  ter_pkg::ofs_t      py_s;
  ter_pkg::pix_beat_t pix_next;

  assign take_ready = !pix_valid || eval_ready;
  assign is_load    = (item.cmd == ter_pkg::CMD_LOAD);
  assign fire       = item_valid && take_ready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= ter_pkg::screen_t'(120);
      screen_height <= ter_pkg::screen_t'(40);
    end else if (cfg_write) begin
      case (cfg_index)
        ter_pkg::REG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        ter_pkg::REG_SCREEN_HEIGHT: screen_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // screen limits, saturated to the largest screen
  always_comb begin
    w_sat = (screen_width > ter_pkg::screen_t'(ter_pkg::SCREEN_MAX))
            ? ter_pkg::screen_t'(ter_pkg::SCREEN_MAX) : screen_width;
    h_sat = (screen_height > ter_pkg::screen_t'(ter_pkg::SCREEN_MAX))
            ? ter_pkg::screen_t'(ter_pkg::SCREEN_MAX) : screen_height;
    w_lim = ter_pkg::ofs_t'(w_sat) - ter_pkg::ofs_t'(1);
    h_lim = ter_pkg::ofs_t'(h_sat) - ter_pkg::ofs_t'(1);
  end

  // clipped bounding box and doubled area test
  always_comb begin
    lo_x = item.min_x[ter_pkg::COORD_BITS-1] ? '0 : ter_pkg::ofs_t'(item.min_x);
    lo_y = item.min_y[ter_pkg::COORD_BITS-1] ? '0 : ter_pkg::ofs_t'(item.min_y);
    hi_x = (ter_pkg::ofs_t'(item.max_x) > w_lim) ? w_lim : ter_pkg::ofs_t'(item.max_x);
    hi_y = (ter_pkg::ofs_t'(item.max_y) > h_lim) ? h_lim : ter_pkg::ofs_t'(item.max_y);
    area_zero = ((ter_pkg::prod_t'(item.dx_ab) * ter_pkg::prod_t'(item.dy_ac)) ==
                 (ter_pkg::prod_t'(item.dy_ab) * ter_pkg::prod_t'(item.dx_ac)));
    tri_empty = area_zero || (lo_x > hi_x) || (lo_y > hi_y);
  end

  // scan position tests
  assign end_row = (scan_x >= box_hi_x);
  assign fin     = end_row && (scan_y >= box_hi_y);
  assign emit    = item_valid && (is_load ? tri_empty : active);
  assign px_s    = ter_pkg::ofs_t'(scan_x);
  assign py_s    = ter_pkg::ofs_t'(scan_y);

  // result beat for the edge stage
  always_comb begin
    pix_next = '0;
    if (is_load) begin
      pix_next.color = item.color;
      pix_next.layer = item.layer;
      pix_next.empty = 1'b1;
      pix_next.last  = 1'b1;
    end else begin
      pix_next.px    = scan_x;
      pix_next.py    = scan_y;
      pix_next.color = held_color;
      pix_next.layer = held_layer;
      pix_next.last  = fin;
      pix_next.dx0   = k_dx0;
      pix_next.dy0   = k_dy0;
      pix_next.ox0   = px_s - ter_pkg::ofs_t'(vx_a);
      pix_next.oy0   = py_s - ter_pkg::ofs_t'(vy_a);
      pix_next.dx1   = k_dx1;
      pix_next.dy1   = k_dy1;
      pix_next.ox1   = px_s - ter_pkg::ofs_t'(vx_b);
      pix_next.oy1   = py_s - ter_pkg::ofs_t'(vy_b);
      pix_next.dx2   = k_dx2;
      pix_next.dy2   = k_dy2;
      pix_next.ox2   = px_s - ter_pkg::ofs_t'(vx_c);
      pix_next.oy2   = py_s - ter_pkg::ofs_t'(vy_c);
    end
  end

  // active flag
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (fire) begin
      if (is_load) begin
        active <= !tri_empty;
      end else if (active && fin) begin
        active <= 1'b0;
      end
    end
  end

  // triangle capture and scan advance
  always_ff @(posedge clk) begin
    if (fire) begin
      if (is_load) begin
        vx_a       <= item.ax;
        vy_a       <= item.ay;
        vx_b       <= item.bx;
        vy_b       <= item.by;
        vx_c       <= item.cx;
        vy_c       <= item.cy;
        k_dx0      <= item.dx_ab;
        k_dy0      <= item.dy_ab;
        k_dx1      <= item.dx_bc;
        k_dy1      <= item.dy_bc;
        k_dx2      <= item.dx_ca;
        k_dy2      <= item.dy_ca;
        held_color <= item.color;
        held_layer <= item.layer;
        box_lo_x   <= lo_x[ter_pkg::PIX_W-1:0];
        box_hi_x   <= hi_x[ter_pkg::PIX_W-1:0];
        box_lo_y   <= lo_y[ter_pkg::PIX_W-1:0];
        box_hi_y   <= hi_y[ter_pkg::PIX_W-1:0];
        scan_x     <= lo_x[ter_pkg::PIX_W-1:0];
        scan_y     <= lo_y[ter_pkg::PIX_W-1:0];
      end else if (active && !fin) begin
        if (end_row) begin
          scan_x <= box_lo_x;
          scan_y <= scan_y + ter_pkg::pix_t'(1);
        end else begin
          scan_x <= scan_x + ter_pkg::pix_t'(1);
        end
      end
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (take_ready) begin
      pix_valid <= emit;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (take_ready && emit) begin
      pix <= pix_next;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/ter_edge_eval.sv
// edge function products, sign test and output register
`timescale 1ns / 1ps
`default_nettype none

module ter_edge_eval (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   pix_valid,
  input  wire ter_pkg::pix_beat_t     pix,
  output logic                        eval_ready,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output ter_pkg::pix_t               pixel_x,
  output ter_pkg::pix_t               pixel_y,
  output logic                        covered,
  output logic [ter_pkg::ATTR_W-1:0]  attribute,
  output ter_pkg::layer_t             layer_out,
  output logic                        empty_res,
  output logic                        last
);

  logic                prod_valid;
  ter_pkg::prod_beat_t prod;
  ter_pkg::prod_beat_t prod_next;
  logic                out_ready;
  ter_pkg::edge_t      e0;
  ter_pkg::edge_t      e1;
  ter_pkg::edge_t      e2;
  logic                all_nonneg;
  logic                all_nonpos;

  assign out_ready  = !out_valid || !out_stall;
  assign eval_ready = !prod_valid || out_ready;

  // products p0a to p2b of the edge functions e0, e1 and e2
  always_comb begin
    prod_next       = '0;
    prod_next.px    = pix.px;
    prod_next.py    = pix.py;
    prod_next.color = pix.color;
    prod_next.layer = pix.layer;
    prod_next.empty = pix.empty;
    prod_next.last  = pix.last;
    prod_next.p0a   = ter_pkg::prod_t'(pix.dx0) * ter_pkg::prod_t'(pix.oy0);
    prod_next.p0b   = ter_pkg::prod_t'(pix.dy0) * ter_pkg::prod_t'(pix.ox0);
    prod_next.p1a   = ter_pkg::prod_t'(pix.dx1) * ter_pkg::prod_t'(pix.oy1);
    prod_next.p1b   = ter_pkg::prod_t'(pix.dy1) * ter_pkg::prod_t'(pix.ox1);
    prod_next.p2a   = ter_pkg::prod_t'(pix.dx2) * ter_pkg::prod_t'(pix.oy2);
    prod_next.p2b   = ter_pkg::prod_t'(pix.dy2) * ter_pkg::prod_t'(pix.ox2);
  end

  // product register
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (eval_ready) begin
      prod_valid <= pix_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (eval_ready && pix_valid) begin
      prod <= prod_next;
    end
  end

  // edge values and winding-free inside test
  always_comb begin
    e0 = ter_pkg::edge_t'(prod.p0a) - ter_pkg::edge_t'(prod.p0b);
    e1 = ter_pkg::edge_t'(prod.p1a) - ter_pkg::edge_t'(prod.p1b);
    e2 = ter_pkg::edge_t'(prod.p2a) - ter_pkg::edge_t'(prod.p2b);
    all_nonneg = !e0[ter_pkg::EDGE_W-1] && !e1[ter_pkg::EDGE_W-1] &&
                 !e2[ter_pkg::EDGE_W-1];
    all_nonpos = (e0[ter_pkg::EDGE_W-1] || (e0 == '0)) &&
                 (e1[ter_pkg::EDGE_W-1] || (e1 == '0)) &&
                 (e2[ter_pkg::EDGE_W-1] || (e2 == '0));
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && prod_valid) begin
      pixel_x   <= prod.px;
      pixel_y   <= prod.py;
      covered   <= !prod.empty && (all_nonneg || all_nonpos);
      attribute <= {prod.color, {ter_pkg::COLOR_SHIFT{1'b0}}};
      layer_out <= prod.layer;
      empty_res <= prod.empty;
      last      <= prod.last;
    end
  end

endmodule

`default_nettype wire
